// ----- sv/cdq_pkg.sv -----
package cdq_pkg;

  // Ring geometry. The ring holds at most DEPTH-1 items.
  localparam int unsigned DEPTH      = 16;
  localparam int unsigned ITEM_WIDTH = 32;
  localparam int unsigned PTR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  // Fixed field widths on the streams.
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned ITEM_IN_W  = 32;
  localparam int unsigned ITEM_OUT_W = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_REAR   = 3'd0,
    ACT_INS_FRONT  = 3'd1,
    ACT_REM_REAR   = 3'd2,
    ACT_REM_FRONT  = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_REAR  = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Everything about an accepted item except the data the RAM returns.
  typedef struct packed {
    logic               rd;
    status_e            status;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } pend_t;

endpackage

// ----- sv/cdq_ram.sv -----
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/circular_deque.sv -----
// Double-ended queue held in a ring of DEPTH entries; at most DEPTH-1 items.
// Requests arrive on the s_axis stream: each item carries an action (insert at
// the rear or front, remove from the rear or front, peek at the front or rear)
// and a data word used by the inserts. Every request yields exactly one item on
// the m_axis stream with the data read, a status (ok, full, empty), the number
// of items held afterwards and an empty flag.
// A result passes the pending stage and then the output register on its way
// to m_axis. Unless the receiver stalls, one request is taken every cycle: the
// pointers are updated in the acceptance cycle and the single-port-read RAM
// returns data in the next cycle, so the sustained rate is one item per cycle.
// The ring data lives in the RAM; the front and rear pointers are registers.
// A request that would overflow or underflow is answered with an error status
// and leaves the deque unchanged.
// Reset empties the deque at once (front pointer one, rear pointer zero); no
// clearing pass is needed since only occupied entries are ever read.
// When the receiver stalls, the result is held in the output register and one
// more request may still be accepted into the pending stage; after that
// s_axis_tready drops until the output drains.
module circular_deque
  import cdq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: action [2:0], item_in [34:3], zero padding [39:35].
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0: item_out [31:0], status [33:32], item_count [37:34],
  // is_empty [38], zero padding [39].
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
  endfunction

  // Items held for a given pair of pointers: (DEPTH + rear + 1 - front) mod DEPTH.
  function automatic logic [CNT_W-1:0] ring_count(input logic [PTR_W-1:0] f,
                                                  input logic [PTR_W-1:0] r);
    logic [CNT_W-1:0] s;
    logic [CNT_W-1:0] d;
    s = {1'b0, r} + CNT_W'(1);
    if (s >= {1'b0, f}) begin
      d = s - {1'b0, f};
    end else begin
      d = s + CNT_W'(DEPTH) - {1'b0, f};
    end
    if (d == CNT_W'(DEPTH)) begin
      d = '0;
    end
    return d;
  endfunction

  // Pointers.
  logic [PTR_W-1:0] front_q, front_d;
  logic [PTR_W-1:0] rear_q, rear_d;

  // Pending stage: waits for the RAM read data.
  logic  pend_valid_q, pend_valid_d;
  pend_t pend_q, pend_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // RAM ports.
  logic                  ram_we, ram_re;
  logic [PTR_W-1:0]      ram_waddr, ram_raddr;
  logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;

  action_e               act;
  logic [ITEM_IN_W-1:0]  item_in;
  logic                  accept, out_free;
  logic                  is_empty_now, is_full_now;
  logic [PTR_W-1:0]      rear_nx, rear_pv, front_nx, front_pv;
  logic [CNT_W-1:0]      count_after;
  logic [ITEM_OUT_W-1:0] item_out;

  assign act     = action_e'(s_axis_tdata[ACTION_W-1:0]);
  assign item_in = s_axis_tdata[ACTION_W +: ITEM_IN_W];

  // The pending stage moves on whenever the output register is free, so a new
  // request can enter in the same cycle.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !pend_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign rear_nx  = ring_next(rear_q);
  assign rear_pv  = ring_prev(rear_q);
  assign front_nx = ring_next(front_q);
  assign front_pv = ring_prev(front_q);

  assign is_empty_now = (rear_nx == front_q);
  assign is_full_now  = (ring_next(rear_nx) == front_q);

  assign ram_wdata = ITEM_WIDTH'(item_in);

  // Decode the request: at most one pointer moves and at most one RAM access.
  // A write lands at the acceptance edge and any read of a later request is taken
  // at a later edge, so reads always see earlier inserts.
  always_comb begin
    front_d     = front_q;
    rear_d      = rear_q;
    ram_we      = 1'b0;
    ram_waddr   = rear_nx;
    ram_raddr   = rear_q;
    pend_d.rd     = 1'b0;
    pend_d.status = ST_OK;
    case (act)
      ACT_INS_REAR: begin
        if (is_full_now) begin
          pend_d.status = ST_FULL;
        end else begin
          rear_d    = rear_nx;
          ram_we    = accept;
          ram_waddr = rear_nx;
        end
      end
      ACT_INS_FRONT: begin
        if (is_full_now) begin
          pend_d.status = ST_FULL;
        end else begin
          front_d   = front_pv;
          ram_we    = accept;
          ram_waddr = front_pv;
        end
      end
      ACT_REM_REAR: begin
        if (is_empty_now) begin
          pend_d.status = ST_EMPTY;
        end else begin
          pend_d.rd = 1'b1;
          ram_raddr = rear_q;
          rear_d    = rear_pv;
        end
      end
      ACT_REM_FRONT: begin
        if (is_empty_now) begin
          pend_d.status = ST_EMPTY;
        end else begin
          pend_d.rd = 1'b1;
          ram_raddr = front_q;
          front_d   = front_nx;
        end
      end
      ACT_PEEK_FRONT: begin
        if (is_empty_now) begin
          pend_d.status = ST_EMPTY;
        end else begin
          pend_d.rd = 1'b1;
          ram_raddr = front_q;
        end
      end
      ACT_PEEK_REAR: begin
        if (is_empty_now) begin
          pend_d.status = ST_EMPTY;
        end else begin
          pend_d.rd = 1'b1;
          ram_raddr = rear_q;
        end
      end
      default: begin
        // Unused action codes leave everything as it stands.
      end
    endcase
    count_after  = ring_count(front_d, rear_d);
    pend_d.count = COUNT_W'(count_after);
    pend_d.empty = (ring_next(rear_d) == front_d);
  end

  assign ram_re = accept && pend_d.rd;

  always_comb begin
    if (accept) begin
      pend_valid_d = 1'b1;
    end else if (out_free) begin
      pend_valid_d = 1'b0;
    end else begin
      pend_valid_d = pend_valid_q;
    end
    out_valid_d = out_free ? pend_valid_q : out_valid_q;
  end

  assign item_out = pend_q.rd ? ITEM_OUT_W'(ram_rdata) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q      <= PTR_W'(1 % DEPTH);
      rear_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        front_q <= front_d;
        rear_q  <= rear_d;
      end
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
    if (out_free && pend_valid_q) begin
      out_data_q <= {1'b0, pend_q.empty, pend_q.count, pend_q.status, item_out};
    end
  end

  cdq_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- sv/cdq_checker.sv -----
module cdq_checker
  import cdq_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [ITEM_OUT_W-1:0] o_item;
  logic [STATUS_W-1:0]   o_status;
  logic [COUNT_W-1:0]    o_count;
  logic                  o_empty;

  assign o_item   = m_axis_tdata[ITEM_OUT_W-1:0];
  assign o_status = m_axis_tdata[ITEM_OUT_W +: STATUS_W];
  assign o_count  = m_axis_tdata[ITEM_OUT_W + STATUS_W +: COUNT_W];
  assign o_empty  = m_axis_tdata[ITEM_OUT_W + STATUS_W + COUNT_W];

  // A stalled result keeps its value until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A failed request never returns data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_status != ST_OK |-> o_item == '0)
    else $error("error result carries data");

  // An overflow is only reported with a full ring.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_status == ST_FULL |-> o_count == COUNT_W'(DEPTH - 1))
    else $error("full status with wrong count");

  // An underflow leaves the deque empty.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_status == ST_EMPTY |-> o_empty && o_count == '0)
    else $error("empty status with items held");

  // The empty flag and a zero count agree.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> o_empty == (o_count == '0))
    else $error("empty flag disagrees with count");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  // The two action codes that the package leaves unnamed. The block must treat
  // them as a no-op that still answers with one result item.
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 8;     // extra wait after the last owed answer
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake on either side
  localparam int RANDOM_ITEMS  = 1400;

  // One predicted answer of the deque.
  typedef struct {
    logic [ITEM_OUT_W-1:0] item;
    status_e               status;
    logic [COUNT_W-1:0]    count;
    logic                  empty;
  } reply_t;

  // Tracks the ring and its two pointers the way the block must, and keeps
  // the answers that are still owed, oldest first.
  class deque_tracker;
    logic [ITEM_WIDTH-1:0] ring [DEPTH];
    int unsigned           front_q;
    int unsigned           rear_q;
    reply_t                owed[$];
    int unsigned           errors;

    function new();
      front_q = 1 % DEPTH;
      rear_q  = 0;
      errors  = 0;
    endfunction

    // Applies one accepted request and queues the answer it must produce.
    function void note_request(logic [ACTION_W-1:0] act, logic [ITEM_IN_W-1:0] item);
      reply_t r;
      bit     was_empty;
      bit     was_full;
      was_empty = ((rear_q + 1) % DEPTH) == front_q;
      was_full  = ((rear_q + 2) % DEPTH) == front_q;
      r.item    = '0;
      r.status  = ST_OK;
      case (act)
        ACT_INS_REAR: begin
          if (was_full) begin
            r.status = ST_FULL;
          end else begin
            rear_q                = (rear_q + 1) % DEPTH;
            ring[PTR_W'(rear_q)] = item[ITEM_WIDTH-1:0];
          end
        end
        ACT_INS_FRONT: begin
          if (was_full) begin
            r.status = ST_FULL;
          end else begin
            front_q                = (front_q + DEPTH - 1) % DEPTH;
            ring[PTR_W'(front_q)] = item[ITEM_WIDTH-1:0];
          end
        end
        ACT_REM_REAR: begin
          if (was_empty) begin
            r.status = ST_EMPTY;
          end else begin
            r.item = ring[PTR_W'(rear_q)];
            rear_q = (rear_q + DEPTH - 1) % DEPTH;
          end
        end
        ACT_REM_FRONT: begin
          if (was_empty) begin
            r.status = ST_EMPTY;
          end else begin
            r.item  = ring[PTR_W'(front_q)];
            front_q = (front_q + 1) % DEPTH;
          end
        end
        ACT_PEEK_FRONT: begin
          if (was_empty) r.status = ST_EMPTY;
          else r.item = ring[PTR_W'(front_q)];
        end
        ACT_PEEK_REAR: begin
          if (was_empty) r.status = ST_EMPTY;
          else r.item = ring[PTR_W'(rear_q)];
        end
        default: begin
        end
      endcase
      r.count = COUNT_W'((DEPTH + rear_q + 1 - front_q) % DEPTH);
      r.empty = ((rear_q + 1) % DEPTH) == front_q;
      owed.push_back(r);
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares one accepted result item with the oldest owed answer.
    function void check_reply(logic [OUT_TDATA_W-1:0] word);
      reply_t r;
      if (owed.size() == 0) begin
        $error("result item 0x%0h arrived with no request outstanding", word);
        errors++;
        return;
      end
      r = owed.pop_front();
      check_field("item_out",   64'(r.item),   64'(word[31:0]));
      check_field("status",     64'(r.status), 64'(word[33:32]));
      check_field("item_count", 64'(r.count),  64'(word[37:34]));
      check_field("is_empty",   64'(r.empty),  64'(word[38]));
      check_field("padding",    64'(0),        64'(word[39]));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // Fields from bit 0: action [2:0], item_in [34:3], zero padding [39:35].
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // Fields from bit 0: item_out [31:0], status [33:32], item_count [37:34],
  // is_empty [38], zero padding [39].
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Idling on the request and result sides can be switched off per phase so
  // that some stretches run at the full rate of one item per cycle.
  bit          src_idles  = 1'b1;
  bit          sink_idles = 1'b1;
  int unsigned stall_left = 0;

  deque_tracker tracker;

  circular_deque u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // One draw in ten picks a long idle stretch; the others pick a short one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Data words lean on the all-zero and all-one extremes, the rest are random.
  function automatic logic [ITEM_IN_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Presents one request and returns at the edge where it is accepted. The
  // valid stays high on return, so a back-to-back request only changes data.
  task automatic send_request(logic [ACTION_W-1:0] act, logic [ITEM_IN_W-1:0] item);
    int unsigned gap;
    gap = (src_idles && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - ACTION_W - ITEM_IN_W){1'b0}}, item, act};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(act, item);
  endtask

  // The result side drops ready for random stretches while idling is enabled.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (sink_idles && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= idle_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every accepted result is checked against the oldest owed answer. Values
  // are sampled at the edge, before any of this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_reply(m_axis_tdata);
  end

  // A hung handshake on both sides ends the run.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned           sent;
    int unsigned           phase_left;
    int unsigned           fill_pct;
    int unsigned           roll;
    logic [ACTION_W-1:0]   act;
    tracker = new();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Start on the empty deque: every remove and peek must
    // report empty, and the spare codes must answer without touching state.
    send_request(ACT_REM_REAR,   pick_word());
    send_request(ACT_REM_FRONT,  pick_word());
    send_request(ACT_PEEK_FRONT, pick_word());
    send_request(ACT_PEEK_REAR,  pick_word());
    send_request(ACT_SPARE_A,    '1);
    send_request(ACT_SPARE_B,    '0);
    // Fill to capacity from both ends, starting with the data extremes; the
    // front pointer wraps below zero on the second front insert.
    send_request(ACT_INS_FRONT, '0);
    send_request(ACT_INS_REAR,  '1);
    for (int i = 0; i < DEPTH - 3; i++) begin
      send_request((i % 2 == 0) ? ACT_INS_FRONT : ACT_INS_REAR,
                   (i % 3 == 0) ? 32'hAAAA_AAAA : (i % 3 == 1) ? 32'h5555_5555 : $urandom);
    end
    // Inserts into the full deque must be refused at both ends.
    send_request(ACT_INS_REAR,   pick_word());
    send_request(ACT_INS_FRONT,  pick_word());
    send_request(ACT_PEEK_FRONT, pick_word());
    send_request(ACT_PEEK_REAR,  pick_word());
    send_request(ACT_REM_FRONT,  pick_word());
    send_request(ACT_REM_REAR,   pick_word());

    // Random part, in phases that lean toward filling, draining or neither,
    // so the deque keeps swinging between full and empty and the pointers
    // wrap many times. A few spare action codes are mixed in as noise.
    sent       = 0;
    phase_left = 0;
    fill_pct   = 50;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(30, 90);
        case ($urandom_range(0, 2))
          0:       fill_pct = 75;
          1:       fill_pct = 25;
          default: fill_pct = 50;
        endcase
        src_idles  = $urandom_range(0, 3) != 0;
        sink_idles = $urandom_range(0, 3) != 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
      end else if ($urandom_range(0, 99) < fill_pct) begin
        act = $urandom_range(0, 1) ? ACT_INS_REAR : ACT_INS_FRONT;
      end else begin
        case ($urandom_range(0, 5))
          0, 1:    act = ACT_REM_REAR;
          2, 3:    act = ACT_REM_FRONT;
          4:       act = ACT_PEEK_FRONT;
          default: act = ACT_PEEK_REAR;
        endcase
      end
      send_request(act, pick_word());
      sent++;
      phase_left--;
    end
    s_axis_tvalid <= 1'b0;

    // Drain every owed answer, then wait SETTLE_CYCLES more so that
    // a stray extra result would still be caught.
    while (tracker.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
